[hdl/swsu_pkg.sv]
// Shared types, codes and constants for the stop-and-wait sender unit.
package swsu_pkg;

  localparam int MAX_PAYLOAD = 1024;
  localparam int LEN_W       = 11;
  localparam int TIMER_W     = 32;
  localparam int RETRY_W     = 4;

  localparam logic [RETRY_W-1:0] RETRY_SAT   = '1;
  localparam logic [TIMER_W-1:0] TIMEOUT_RST = 32'd100000000;
  localparam logic [RETRY_W-1:0] RETRY_RST   = 4'd3;

  // Request type codes on the input channel.
  localparam logic [2:0] REQ_PAYLOAD  = 3'd0;
  localparam logic [2:0] REQ_END      = 3'd1;
  localparam logic [2:0] REQ_TICK     = 3'd2;
  localparam logic [2:0] REQ_ACK_BYTE = 3'd3;
  localparam logic [2:0] REQ_ACK_HDR  = 3'd4;

  // Configuration register indexes.
  localparam logic [7:0] CFG_TIMEOUT = 8'd0;
  localparam logic [7:0] CFG_RETRY   = 8'd1;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_SEND    = 3'd1,
    ACT_TIMEOUT = 3'd2,
    ACT_BADSUM  = 3'd3,
    ACT_BADSEQ  = 3'd4,
    ACT_DONE    = 3'd5,
    ACT_GAVEUP  = 3'd6
  } act_t;

  typedef enum logic [2:0] {
    K_IGNORE,
    K_BYTE,
    K_END,
    K_TICK,
    K_ACK_BYTE,
    K_ACK_HDR
  } kind_t;

  // One classified transaction as it travels from front to back.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_val;
    logic [7:0] hdr_xor;   // XOR of ack_seq and ack_len bytes
    logic [7:0] ck_low;    // low byte of ack_cksum
    logic       ck_up0;    // upper 24 bits of ack_cksum all zero
    logic       ck_up1;    // upper 24 bits of ack_cksum all one
    logic       seq_is0;
    logic       seq_is1;
  } item_t;

endpackage

[hdl/swsu_front.sv]
// Front end: decodes a request and precomputes the ack header checks.
module swsu_front import swsu_pkg::*; (
  input  logic        [2:0]       req_type,
  input  logic        [7:0]       byte_value,
  input  logic signed [31:0]      ack_seq,
  input  logic        [LEN_W-1:0] ack_len,
  input  logic signed [31:0]      ack_cksum,
  output item_t                   item
);

  always_comb begin
    item = '0;
    case (req_type)
      REQ_PAYLOAD:  item.kind = K_BYTE;
      REQ_END:      item.kind = K_END;
      REQ_TICK:     item.kind = K_TICK;
      REQ_ACK_BYTE: item.kind = K_ACK_BYTE;
      REQ_ACK_HDR:  item.kind = K_ACK_HDR;
      default:      item.kind = K_IGNORE;
    endcase
    item.byte_val = byte_value;
    item.hdr_xor  = ack_seq[7:0] ^ ack_seq[15:8] ^ ack_seq[23:16] ^ ack_seq[31:24]
                  ^ ack_len[7:0] ^ {5'd0, ack_len[LEN_W-1:8]};
    item.ck_low   = ack_cksum[7:0];
    item.ck_up0   = (ack_cksum[31:8] == 24'h000000);
    item.ck_up1   = (ack_cksum[31:8] == 24'hFFFFFF);
    item.seq_is0  = (ack_seq == 32'sd0);
    item.seq_is1  = (ack_seq == 32'sd1);
  end

endmodule

[hdl/swsu_queue.sv]
// Two-entry queue of classified transactions between front and back.
module swsu_queue import swsu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  output logic  pop_valid,
  input  logic  pop,
  output item_t pop_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[hdl/swsu_back.sv]
// Back end: sender state machine, timer, retries and the result register.
module swsu_back import swsu_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic        [TIMER_W-1:0] timeout_ticks,
  input  logic        [RETRY_W-1:0] retry_limit,
  input  logic                      q_valid,
  input  item_t                     q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic        [2:0]         out_action,
  output logic                      out_pkt_seq,
  output logic        [LEN_W-1:0]   out_pkt_len,
  output logic signed [7:0]         out_pkt_cksum,
  output logic                      out_busy_res
);

  typedef enum logic {ST_IDLE, ST_WAIT} st_t;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PAYLOAD);

  st_t                st_r, st_nxt;
  logic               seq_r, seq_nxt;
  logic [LEN_W-1:0]   count_r, count_nxt;
  logic [7:0]         pxor_r, pxor_nxt;
  logic [7:0]         axor_r, axor_nxt;
  logic [RETRY_W-1:0] retry_r, retry_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;

  logic               ov_r, ov_nxt;
  act_t               act_r, act_nxt;
  logic               oseq_r, oseq_nxt;
  logic [LEN_W-1:0]   olen_r, olen_nxt;
  logic [7:0]         ock_r, ock_nxt;
  logic               obusy_r, obusy_nxt;

  logic               go;
  logic [7:0]         pkt_sum;
  logic [RETRY_W-1:0] retry_inc;
  logic [7:0]         ack_x;
  logic               sum_ok;
  logic               seq_ok;
  logic               with_pkt;

  assign go    = q_valid && (!ov_r || out_ready);
  assign q_pop = go;

  assign pkt_sum   = {7'd0, seq_r} ^ count_r[7:0] ^ {5'd0, count_r[LEN_W-1:8]} ^ pxor_r;
  assign retry_inc = (retry_r == RETRY_SAT) ? retry_r : retry_r + 1'b1;
  assign ack_x     = q_item.hdr_xor ^ axor_r;
  assign sum_ok    = (ack_x == q_item.ck_low) && (ack_x[7] ? q_item.ck_up1 : q_item.ck_up0);
  assign seq_ok    = seq_r ? q_item.seq_is1 : q_item.seq_is0;

  always_comb begin
    st_nxt    = st_r;
    seq_nxt   = seq_r;
    count_nxt = count_r;
    pxor_nxt  = pxor_r;
    axor_nxt  = axor_r;
    retry_nxt = retry_r;
    timer_nxt = timer_r;
    act_nxt   = ACT_NONE;
    obusy_nxt = (st_r == ST_WAIT);

    case (st_r)
      ST_IDLE: begin
        case (q_item.kind)
          K_BYTE: begin
            if (count_r < MAX_LEN) begin
              pxor_nxt  = pxor_r ^ q_item.byte_val;
              count_nxt = count_r + 1'b1;
            end
          end
          K_END: begin
            st_nxt    = ST_WAIT;
            retry_nxt = '0;
            axor_nxt  = '0;
            timer_nxt = timeout_ticks;
            act_nxt   = ACT_SEND;
            obusy_nxt = 1'b1;
          end
          default: ;
        endcase
      end
      ST_WAIT: begin
        case (q_item.kind)
          K_TICK: begin
            if (timer_r > TIMER_W'(1)) begin
              timer_nxt = timer_r - 1'b1;
            end else if (retry_inc >= retry_limit) begin
              act_nxt = ACT_GAVEUP;
            end else begin
              retry_nxt = retry_inc;
              timer_nxt = timeout_ticks;
              act_nxt   = ACT_TIMEOUT;
            end
          end
          K_ACK_BYTE: axor_nxt = axor_r ^ q_item.byte_val;
          K_ACK_HDR: begin
            axor_nxt = '0;
            if (!sum_ok) begin
              timer_nxt = timeout_ticks;
              act_nxt   = ACT_BADSUM;
            end else if (!seq_ok) begin
              timer_nxt = timeout_ticks;
              act_nxt   = ACT_BADSEQ;
            end else begin
              act_nxt = ACT_DONE;
            end
          end
          default: ;
        endcase
        // A delivered or abandoned packet closes out and flips the sequence bit.
        if (act_nxt == ACT_DONE || act_nxt == ACT_GAVEUP) begin
          st_nxt    = ST_IDLE;
          seq_nxt   = ~seq_r;
          count_nxt = '0;
          pxor_nxt  = '0;
          axor_nxt  = '0;
          retry_nxt = '0;
          timer_nxt = '0;
          obusy_nxt = 1'b0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase

    with_pkt = (act_nxt != ACT_NONE);
    oseq_nxt = with_pkt ? seq_r   : 1'b0;
    olen_nxt = with_pkt ? count_r : '0;
    ock_nxt  = with_pkt ? pkt_sum : '0;

    ov_nxt = go ? 1'b1 : (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      seq_r   <= 1'b0;
      count_r <= '0;
      pxor_r  <= '0;
      axor_r  <= '0;
      retry_r <= '0;
      timer_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (go) begin
        st_r    <= st_nxt;
        seq_r   <= seq_nxt;
        count_r <= count_nxt;
        pxor_r  <= pxor_nxt;
        axor_r  <= axor_nxt;
        retry_r <= retry_nxt;
        timer_r <= timer_nxt;
      end
    end
    if (go) begin
      act_r   <= act_nxt;
      oseq_r  <= oseq_nxt;
      olen_r  <= olen_nxt;
      ock_r   <= ock_nxt;
      obusy_r <= obusy_nxt;
    end
  end

  assign out_valid     = ov_r;
  assign out_action    = act_r;
  assign out_pkt_seq   = oseq_r;
  assign out_pkt_len   = olen_r;
  assign out_pkt_cksum = ock_r;
  assign out_busy_res  = obusy_r;

endmodule

[hdl/stop_and_wait_sender_unit.sv]
// Top level of the alternating-bit stop-and-wait sender unit.
// Path: an accepted transaction waits in the two-entry queue until the back end pops it, and its
// result is then held in the result register until the consumer takes it.
// Throughput: one transaction per cycle while results are taken, set by the state update in the back end.
// Reset (rst_n low, synchronous): queue and result register empty, sender idle with sequence
// bit 0, timeout_ticks 100000000 and retry_limit 3. No clearing pass is needed.
module stop_and_wait_sender_unit import swsu_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic        [2:0]   in_req_type,
  input  logic        [7:0]   in_byte_value,
  input  logic signed [31:0]  in_ack_seq,
  input  logic        [10:0]  in_ack_len,
  input  logic signed [31:0]  in_ack_cksum,

  output logic                out_valid,
  input  logic                out_ready,
  output logic        [2:0]   out_action,
  output logic                out_pkt_seq,
  output logic        [10:0]  out_pkt_len,
  output logic signed [7:0]   out_pkt_cksum,
  output logic                out_busy_res,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic        [7:0]   cfg_index,
  input  logic        [31:0]  cfg_data
);

  // Configuration registers. Writes are always taken; an index beyond the
  // register list is accepted and dropped.
  logic [TIMER_W-1:0] timeout_r, timeout_nxt;
  logic [RETRY_W-1:0] limit_r, limit_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    timeout_nxt = timeout_r;
    limit_nxt   = limit_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_nxt = cfg_data;
        CFG_RETRY:   limit_nxt   = cfg_data[RETRY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RST;
      limit_r   <= RETRY_RST;
    end else begin
      timeout_r <= timeout_nxt;
      limit_r   <= limit_nxt;
    end
  end

  // The front end classifies each transaction and does the header XOR and
  // compare work that needs no sender state, so the back end only has to
  // fold in the running ack XOR and the current sequence bit.
  item_t front_item;
  item_t back_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  swsu_front u_front (
    .req_type   (in_req_type),
    .byte_value (in_byte_value),
    .ack_seq    (in_ack_seq),
    .ack_len    (in_ack_len),
    .ack_cksum  (in_ack_cksum),
    .item       (front_item)
  );

  // The queue lets the input keep flowing while the result register waits
  // on a stalled consumer.
  assign in_ready = !q_full;

  swsu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid && in_ready),
    .push_item (front_item),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_item  (back_item)
  );

  // The back end retires one queued transaction per cycle whenever the
  // result register is empty or being emptied, and every transaction
  // yields exactly one result.
  swsu_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .timeout_ticks (timeout_r),
    .retry_limit   (limit_r),
    .q_valid       (q_valid),
    .q_item        (back_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_action    (out_action),
    .out_pkt_seq   (out_pkt_seq),
    .out_pkt_len   (out_pkt_len),
    .out_pkt_cksum (out_pkt_cksum),
    .out_busy_res  (out_busy_res)
  );

endmodule

[bench/swsu_checker.sv]
// Scoreboard for the stop-and-wait sender unit: predicts each result and compares it.
`timescale 1ns / 1ps

module swsu_checker import swsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_byte_value,
  input  logic [31:0] in_ack_seq,
  input  logic [10:0] in_ack_len,
  input  logic [31:0] in_ack_cksum,

  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_action,
  input  logic        out_pkt_seq,
  input  logic [10:0] out_pkt_len,
  input  logic [7:0]  out_pkt_cksum,
  input  logic        out_busy_res,

  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data,

  output int          errors,
  output int          pending,
  output int          results,
  output logic [7:0]  actions_seen,
  output logic        hint_waiting,
  output logic        hint_seq,
  output logic [7:0]  hint_ack_xor
);

  typedef struct packed {
    act_t        action;
    logic        seq;
    logic [10:0] len;
    logic [7:0]  cksum;
    logic        busy;
  } outcome_t;

  logic [31:0] timeout_ticks;
  logic [3:0]  retry_limit;

  logic        seq_bit;
  logic [10:0] payload_count;
  logic [7:0]  payload_xor;
  logic [7:0]  ack_xor;
  logic        waiting;
  logic [3:0]  retry_count;
  logic [31:0] timer_left;

  outcome_t    pending_outcomes[$];

  assign hint_waiting = waiting;
  assign hint_seq     = seq_bit;
  assign hint_ack_xor = ack_xor;

  // Header and payload description of the packet currently held.
  function automatic outcome_t packet_view(input act_t act);
    outcome_t o;
    o        = '0;
    o.action = act;
    o.seq    = seq_bit;
    o.len    = payload_count;
    o.cksum  = {7'd0, seq_bit} ^ payload_count[7:0] ^ {5'd0, payload_count[10:8]} ^ payload_xor;
    return o;
  endfunction

  function automatic void retire_packet();
    waiting       = 1'b0;
    seq_bit       = ~seq_bit;
    payload_count = '0;
    payload_xor   = '0;
    ack_xor       = '0;
    retry_count   = '0;
    timer_left    = '0;
  endfunction

  function automatic outcome_t advance_sender(input logic [2:0] kind, input logic [7:0] b,
                                              input logic [31:0] aseq, input logic [10:0] alen,
                                              input logic [31:0] asum);
    outcome_t    o;
    logic [7:0]  fold;
    logic [31:0] want_sum;
    o        = '0;
    o.action = ACT_NONE;
    if (!waiting) begin
      if (kind == REQ_PAYLOAD) begin
        if (payload_count < MAX_PAYLOAD) begin
          payload_xor   = payload_xor ^ b;
          payload_count = payload_count + 11'd1;
        end
      end else if (kind == REQ_END) begin
        waiting     = 1'b1;
        retry_count = '0;
        ack_xor     = '0;
        timer_left  = timeout_ticks;
        o           = packet_view(ACT_SEND);
      end
    end else begin
      case (kind)
        REQ_TICK: begin
          if (timer_left > 32'd1) begin
            timer_left = timer_left - 32'd1;
          end else begin
            if (retry_count != RETRY_SAT) retry_count = retry_count + 4'd1;
            if (retry_count >= retry_limit) begin
              o = packet_view(ACT_GAVEUP);
              retire_packet();
            end else begin
              timer_left = timeout_ticks;
              o          = packet_view(ACT_TIMEOUT);
            end
          end
        end
        REQ_ACK_BYTE: ack_xor = ack_xor ^ b;
        REQ_ACK_HDR: begin
          fold = aseq[7:0] ^ aseq[15:8] ^ aseq[23:16] ^ aseq[31:24] ^
                 alen[7:0] ^ {5'd0, alen[10:8]} ^ ack_xor;
          want_sum = {{24{fold[7]}}, fold};
          ack_xor  = '0;
          if (want_sum != asum) begin
            timer_left = timeout_ticks;
            o          = packet_view(ACT_BADSUM);
          end else if (aseq != {31'd0, seq_bit}) begin
            timer_left = timeout_ticks;
            o          = packet_view(ACT_BADSEQ);
          end else begin
            o = packet_view(ACT_DONE);
            retire_packet();
          end
        end
        default: ;
      endcase
    end
    o.busy = waiting;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      timeout_ticks = TIMEOUT_RST;
      retry_limit   = RETRY_RST;
      seq_bit       = 1'b0;
      payload_count = '0;
      payload_xor   = '0;
      ack_xor       = '0;
      waiting       = 1'b0;
      retry_count   = '0;
      timer_left    = '0;
      pending_outcomes.delete();
      errors        = 0;
      results       = 0;
      actions_seen  = '0;
      pending       = 0;
    end else begin
      if (out_valid && out_ready) begin
        results++;
        if (!$isunknown(out_action)) actions_seen[out_action] = 1'b1;
        if (pending_outcomes.size() == 0) begin
          $error("result transaction with no expectation pending, action %0d", out_action);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          check_field("action", want.action, out_action);
          check_field("pkt_seq", want.seq, out_pkt_seq);
          check_field("pkt_len", want.len, out_pkt_len);
          check_field("pkt_cksum", want.cksum, out_pkt_cksum);
          check_field("busy_res", want.busy, out_busy_res);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TIMEOUT: timeout_ticks = cfg_data;
          CFG_RETRY:   retry_limit   = cfg_data[3:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pending_outcomes.push_back(advance_sender(in_req_type, in_byte_value, in_ack_seq,
                                                  in_ack_len, in_ack_cksum));
      pending = pending_outcomes.size();
    end
  end

endmodule

[bench/tb.sv]
// Top-level testbench for the stop-and-wait sender unit: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb import swsu_pkg::*;;

  // Random waits are drawn per transaction from 0 up to this many cycles.
  localparam int GAP_MAX        = 13;
  // Random phase length in request transactions. Six phases give roughly 500, and with
  // the directed part and the oversized packet the run comes to about 1550.
  localparam int PHASE_ITEMS    = 80;
  // The result side freezes this long twice so the input queue fills and backs up.
  localparam int HOLD_CYCLES    = 240;
  // A result trails its request through the queue and the result register; wait out that
  // path before touching registers or ending the run.
  localparam int DRAIN_CYCLES   = 6;
  // Longest correct quiet stretch is one hold-off plus a sender gap and a receiver
  // stall on top; the limit leaves a wide margin over that.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;

  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [7:0]  in_byte_value;
  logic signed [31:0] in_ack_seq;
  logic [10:0] in_ack_len;
  logic signed [31:0] in_ack_cksum;

  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_action;
  logic        out_pkt_seq;
  logic [10:0] out_pkt_len;
  logic signed [7:0] out_pkt_cksum;
  logic        out_busy_res;

  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  int          errors;
  int          pending;
  int          results;
  logic [7:0]  actions_seen;
  logic        hint_waiting;
  logic        hint_seq;
  logic [7:0]  hint_ack_xor;

  int          issued;
  int          send_calm;
  int          recv_calm;
  int          quiet_cycles;

  // 12 ns period clock.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stop_and_wait_sender_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_ack_seq    (in_ack_seq),
    .in_ack_len    (in_ack_len),
    .in_ack_cksum  (in_ack_cksum),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_action    (out_action),
    .out_pkt_seq   (out_pkt_seq),
    .out_pkt_len   (out_pkt_len),
    .out_pkt_cksum (out_pkt_cksum),
    .out_busy_res  (out_busy_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // The checker watches all three channels. Besides the failure count it exposes its
  // view of the protocol state, which the stimulus uses to build acks that pass.
  swsu_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_byte_value (in_byte_value),
    .in_ack_seq    (in_ack_seq),
    .in_ack_len    (in_ack_len),
    .in_ack_cksum  (in_ack_cksum),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_action    (out_action),
    .out_pkt_seq   (out_pkt_seq),
    .out_pkt_len   (out_pkt_len),
    .out_pkt_cksum (out_pkt_cksum),
    .out_busy_res  (out_busy_res),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .results       (results),
    .actions_seen  (actions_seen),
    .hint_waiting  (hint_waiting),
    .hint_seq      (hint_seq),
    .hint_ack_xor  (hint_ack_xor)
  );

  // Per-transaction wait. Mostly uniform, but now and then a run of back-to-back
  // transactions so the block also sees full-rate traffic.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, GAP_MAX);
  endfunction

  // Checksum field that an ack header must carry to be accepted, given the ack bytes
  // folded so far.
  function automatic logic [31:0] ack_check_value(input logic [31:0] aseq,
                                                  input logic [10:0] alen,
                                                  input logic [7:0] folded);
    logic [7:0] x;
    x = aseq[7:0] ^ aseq[15:8] ^ aseq[23:16] ^ aseq[31:24] ^
        alen[7:0] ^ {5'd0, alen[10:8]} ^ folded;
    return {{24{x[7]}}, x};
  endfunction

  // Offers one request transaction. Entered and left at a falling edge; valid stays
  // high on return so a zero wait gives back-to-back transactions.
  task automatic push_request(input logic [2:0] kind, input logic [7:0] b,
                              input logic [31:0] aseq, input logic [10:0] alen,
                              input logic [31:0] asum);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_req_type   = kind;
    in_byte_value = b;
    in_ack_seq    = aseq;
    in_ack_len    = alen;
    in_ack_cksum  = asum;
    in_valid      = 1'b1;
    do @(posedge clk); while (!in_ready);
    issued++;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] index, input logic [31:0] value);
    cfg_index = index;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Stops offering requests and waits until every predicted result has been taken,
  // then DRAIN_CYCLES more so nothing is still in flight inside the block.
  task automatic drain();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // One random phase under a given register setting. While the sender is idle the
  // traffic is mostly payload chunks closed by an end of chunk; while it waits, mostly
  // ack sequences (good, bad checksum, bad sequence) and ticks. A share of raw noise
  // with any type code, including the unused ones, is mixed in throughout.
  task automatic run_phase(input logic [31:0] ticks, input logic [3:0] limit);
    int          stop_at;
    int          count;
    int          pick;
    logic [31:0] seq_word;
    logic [10:0] len_word;
    logic [31:0] sum_word;
    drain();
    write_reg(CFG_TIMEOUT, ticks);
    write_reg(CFG_RETRY, {28'd0, limit});
    stop_at = issued + PHASE_ITEMS;
    while (issued < stop_at) begin
      pick = $urandom_range(0, 19);
      if (!hint_waiting) begin
        if (pick == 0) begin
          push_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                       11'($urandom_range(0, 2047)), $urandom);
        end else begin
          count = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 6);
          repeat (count)
            push_request(REQ_PAYLOAD, 8'($urandom), $urandom, 11'($urandom_range(0, 2047)),
                         $urandom);
          push_request(REQ_END, 8'($urandom), $urandom, 11'($urandom_range(0, 2047)),
                       $urandom);
        end
      end else if (pick < 12) begin
        count = $urandom_range(0, 4);
        repeat (count)
          push_request(REQ_ACK_BYTE, 8'($urandom), $urandom, 11'($urandom_range(0, 2047)),
                       $urandom);
        // The header is built after the ack bytes went in, so the folded value is current.
        len_word = 11'($urandom_range(0, 2047));
        if (pick >= 10 && $urandom_range(0, 1) == 1)
          seq_word = $urandom;
        else if (pick >= 10)
          seq_word = {31'd0, ~hint_seq};
        else
          seq_word = {31'd0, hint_seq};
        sum_word = ack_check_value(seq_word, len_word, hint_ack_xor);
        if (pick >= 8 && pick < 10)
          sum_word = sum_word ^ (32'd1 << $urandom_range(0, 31));
        push_request(REQ_ACK_HDR, 8'($urandom), seq_word, len_word, sum_word);
      end else if (pick < 17) begin
        repeat ($urandom_range(1, 4))
          push_request(REQ_TICK, 8'($urandom), $urandom, 11'($urandom_range(0, 2047)),
                       $urandom);
      end else begin
        push_request(3'($urandom_range(0, 7)), 8'($urandom), $urandom,
                     11'($urandom_range(0, 2047)), $urandom);
      end
    end
    // Close any packet still out so the next phase starts from an idle sender.
    while (hint_waiting)
      push_request(REQ_ACK_HDR, 8'd0, {31'd0, hint_seq}, 11'd0,
                   ack_check_value({31'd0, hint_seq}, 11'd0, hint_ack_xor));
  endtask

  // Result side. Each result gets its own random stall. Twice during the run the
  // receiver stops completely for a long stretch while requests keep coming, which
  // fills the block and must push back on the request channel.
  initial begin : result_sink
    int stall;
    int taken;
    out_ready = 1'b0;
    taken     = 0;
    recv_calm = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (taken == 200 || taken == 900) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // Watchdog: any accepted transaction on any channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL stop_and_wait_sender_unit");
      $finish;
    end
  end

  initial begin : stimulus
    in_valid      = 1'b0;
    in_req_type   = REQ_PAYLOAD;
    in_byte_value = '0;
    in_ack_seq    = '0;
    in_ack_len    = '0;
    in_ack_cksum  = '0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_TIMEOUT;
    cfg_data      = '0;
    issued        = 0;
    send_calm     = 0;
    rst_n         = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part under the reset register values (long timeout, three retries).
    // Requests that only make sense while waiting are ignored while idle, and so are
    // the unused type codes.
    push_request(REQ_TICK, 8'hFF, 32'hFFFF_FFFF, 11'h7FF, 32'hFFFF_FFFF);
    push_request(REQ_ACK_BYTE, 8'hA5, 32'd0, 11'd0, 32'd0);
    push_request(REQ_ACK_HDR, 8'h00, 32'd0, 11'd0, 32'd0);
    push_request(3'd7, 8'hFF, 32'h8000_0000, 11'd1024, 32'h7FFF_FFFF);
    push_request(3'd5, 8'h00, 32'd1, 11'd1, 32'd1);
    // A two-byte packet with both byte extremes, sent with sequence bit 0.
    push_request(REQ_PAYLOAD, 8'h00, 32'd0, 11'd0, 32'd0);
    push_request(REQ_PAYLOAD, 8'hFF, 32'd0, 11'd0, 32'd0);
    push_request(REQ_END, 8'h00, 32'd0, 11'd0, 32'd0);
    // While waiting, new payload, a second end of chunk and an unused code do nothing.
    push_request(REQ_PAYLOAD, 8'h3C, 32'd0, 11'd0, 32'd0);
    push_request(REQ_END, 8'h00, 32'd0, 11'd0, 32'd0);
    push_request(3'd6, 8'h81, 32'd0, 11'd0, 32'd0);
    push_request(REQ_ACK_BYTE, 8'hFF, 32'd0, 11'd0, 32'd0);
    push_request(REQ_ACK_BYTE, 8'h5A, 32'd0, 11'd0, 32'd0);
    // Bad checksum on the most negative sequence field, then a header whose checksum
    // is right but whose sequence field is all ones.
    push_request(REQ_ACK_HDR, 8'h00, 32'h8000_0000, 11'd1024, 32'h7FFF_FFFF);
    push_request(REQ_ACK_HDR, 8'h00, 32'hFFFF_FFFF, 11'd1024,
                 ack_check_value(32'hFFFF_FFFF, 11'd1024, hint_ack_xor));
    push_request(REQ_TICK, 8'h00, 32'd0, 11'd0, 32'd0);
    push_request(REQ_ACK_HDR, 8'h00, {31'd0, hint_seq}, 11'h7FF,
                 ack_check_value({31'd0, hint_seq}, 11'h7FF, hint_ack_xor));

    // Zero timeout and zero retry limit: the empty final packet gives up on the
    // first tick.
    drain();
    write_reg(CFG_TIMEOUT, 32'd0);
    write_reg(CFG_RETRY, 32'd0);
    push_request(REQ_END, 8'h00, 32'd0, 11'd0, 32'd0);
    push_request(REQ_TICK, 8'h00, 32'd0, 11'd0, 32'd0);

    // Timeout of two ticks with two retries: one countdown tick, one resend, then
    // a second countdown and the give-up.
    drain();
    write_reg(CFG_TIMEOUT, 32'd2);
    write_reg(CFG_RETRY, 32'd2);
    push_request(REQ_END, 8'h00, 32'd0, 11'd0, 32'd0);
    repeat (4) push_request(REQ_TICK, 8'h00, 32'd0, 11'd0, 32'd0);

    // Random phases across register settings, the extremes among them.
    run_phase(32'd3, 4'd3);
    run_phase(32'd1, 4'd15);
    run_phase(32'hFFFF_FFFF, 4'd15);
    run_phase(32'd2, 4'd1);
    run_phase(32'd0, 4'd4);
    run_phase(32'd5, 4'd7);

    // One packet longer than the payload limit, back on the reset register values.
    // The extra bytes must be dropped and the length must stop at the maximum.
    drain();
    write_reg(CFG_TIMEOUT, TIMEOUT_RST);
    write_reg(CFG_RETRY, {28'd0, RETRY_RST});
    repeat (MAX_PAYLOAD + 3)
      push_request(REQ_PAYLOAD, 8'($urandom), $urandom, 11'($urandom_range(0, 2047)),
                   $urandom);
    push_request(REQ_END, 8'h00, 32'd0, 11'd0, 32'd0);
    push_request(REQ_ACK_HDR, 8'h00, {31'd0, hint_seq}, 11'd1024,
                 ack_check_value({31'd0, hint_seq}, 11'd1024, hint_ack_xor));

    drain();
    $display("Summary: %0d request transactions and %0d results over nine register settings,",
             issued, results);
    $display("  including zero timeout and retry limit, and a packet past %0d bytes; actions %b.",
             MAX_PAYLOAD, actions_seen);
    if (errors == 0) begin
      $display("PASS stop_and_wait_sender_unit");
    end else begin
      $display("FAIL stop_and_wait_sender_unit");
    end
    $finish;
  end

endmodule
